// ===== rtl/pkhash_pkg.sv =====
// ----------------------------------------------------------------------------
// pkhash_pkg
// Types, constants and the FNV-1a fold function shared by the path key
// normalize and hash block.
// ----------------------------------------------------------------------------
package pkhash_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    typedef struct packed {
        logic [31:0] hash;
        logic        at_start;
        logic        held_dot;
        logic        prev_slash;
    } pkhash_state_t;

    typedef struct packed {
        logic [31:0] hash;
        logic        empty;
    } pkhash_result_t;

    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = h ^ {24'd0, b};
            return 32'(x * FNV_PRIME);
        end
    endfunction

    // A held leading dot is only ever folded into the offset basis.
    localparam logic [31:0] HASH_DOT = fnv_fold(FNV_BASIS, CHAR_DOT);

    localparam pkhash_state_t STATE_RESET = '{
        hash:       FNV_BASIS,
        at_start:   1'b1,
        held_dot:   1'b0,
        prev_slash: 1'b0
    };

endpackage

// ===== rtl/pkhash_step.sv =====
// ----------------------------------------------------------------------------
// pkhash_step
// Normalizes one key byte and folds it into the running FNV-1a hash. Gives
// the next state and the result for a final byte.
// ----------------------------------------------------------------------------
module pkhash_step
(
    input  pkhash_pkg::pkhash_state_t  state,
    input  logic [7:0]                 key_byte,
    input  logic                       is_last,
    output pkhash_pkg::pkhash_state_t  state_next,
    output pkhash_pkg::pkhash_result_t result
);

    logic [7:0]  c;
    logic [7:0]  lc;
    logic        is_slash;
    logic        is_dot;
    logic        fold_en;
    logic        use_dot_base;
    logic        held_next;
    logic [31:0] base_hash;
    logic [31:0] folded;
    pkhash_pkg::pkhash_state_t upd;

    assign c        = (key_byte == pkhash_pkg::CHAR_BACKSLASH) ? pkhash_pkg::CHAR_SLASH
                                                               : key_byte;
    assign is_slash = (c == pkhash_pkg::CHAR_SLASH);
    assign is_dot   = (c == pkhash_pkg::CHAR_DOT);
    assign lc       = (c >= pkhash_pkg::CHAR_UPPER_A && c <= pkhash_pkg::CHAR_UPPER_Z)
                      ? c + pkhash_pkg::CASE_OFFSET : c;

    always_comb
    begin
        fold_en      = 1'b0;
        use_dot_base = 1'b0;
        held_next    = 1'b0;
        if (state.at_start)
        begin
            if (state.held_dot)
            begin
                if (!is_slash)
                begin
                    fold_en      = 1'b1;
                    use_dot_base = 1'b1;
                end
            end
            else if (is_dot)
            begin
                held_next = 1'b1;
            end
            else if (!is_slash)
            begin
                fold_en = 1'b1;
            end
        end
        else
        begin
            fold_en = !(is_slash && state.prev_slash);
        end
    end

    assign base_hash = use_dot_base ? pkhash_pkg::HASH_DOT : state.hash;
    assign folded    = pkhash_pkg::fnv_fold(base_hash, lc);

    always_comb
    begin
        upd.hash       = fold_en ? folded : state.hash;
        upd.at_start   = fold_en ? 1'b0 : state.at_start;
        upd.held_dot   = held_next;
        upd.prev_slash = fold_en ? is_slash : state.prev_slash;
    end

    always_comb
    begin
        if (held_next)
        begin
            result.hash  = pkhash_pkg::HASH_DOT;
            result.empty = 1'b0;
        end
        else
        begin
            result.hash  = upd.hash;
            result.empty = upd.at_start;
        end
        state_next = is_last ? pkhash_pkg::STATE_RESET : upd;
    end

endmodule

// ===== rtl/path_key_normalize_hash_top.sv =====
// ----------------------------------------------------------------------------
// path_key_normalize_hash_top
// Streams path key bytes, normalizes them and hashes them with FNV-1a.
// ----------------------------------------------------------------------------
// A result passes the input register, then the result register. The fold is
// one constant multiply. Throughput: one byte per cycle, except that a final
// byte waits in the input register while the output holds an untaken result.
// Reset clears the valid flags and sets the hash to the offset basis.
module path_key_normalize_hash_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] key_hash
    output logic [0:0]  m_tuser    // [0] key_empty
);

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    pkhash_pkg::pkhash_state_t  state_reg;
    pkhash_pkg::pkhash_state_t  state_next;
    pkhash_pkg::pkhash_result_t result;
    logic                       out_valid_reg;
    logic [31:0]                out_hash_reg;
    logic                       out_empty_reg;
    logic                       out_free;
    logic                       advance;

    pkhash_step u_step
    (
        .state      (state_reg),
        .key_byte   (in_byte_reg),
        .is_last    (in_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= pkhash_pkg::STATE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_hash_reg  <= result.hash;
            out_empty_reg <= result.empty;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_hash_reg;
    assign m_tuser[0] = out_empty_reg;

endmodule

// ===== verif/path_key_normalize_hash_top_test.sv =====
// ----------------------------------------------------------------------------
// path_key_normalize_hash_top_test
// Streams path keys byte by byte into the normalize and hash block. It tracks
// the normalization and the FNV-1a hash of each key on the side and checks
// every result hash and empty flag as the results arrive, under several
// mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module path_key_normalize_hash_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 6;
    localparam int REPORT_LIMIT = 10;
    localparam int BYTES_PER_PHASE = 310;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count = 0;

    logic [31:0] key_hash_now;
    logic        key_at_start;
    logic        key_held_dot;
    logic        key_prev_slash;

    pkhash_pkg::pkhash_result_t key_result_q[$];
    logic [7:0]                 key_buf[$];

    path_key_normalize_hash_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_key_state();
        key_hash_now   = pkhash_pkg::FNV_BASIS;
        key_at_start   = 1'b1;
        key_held_dot   = 1'b0;
        key_prev_slash = 1'b0;
    endtask

    task automatic add_key_char(input logic [7:0] ch);
        key_buf.insert(key_buf.size(), ch);
    endtask

    task automatic fold_key_char(input logic [7:0] ch);
        logic [7:0] b;
        b = ch;
        if (b >= pkhash_pkg::CHAR_UPPER_A && b <= pkhash_pkg::CHAR_UPPER_Z)
            b = b + pkhash_pkg::CASE_OFFSET;
        key_hash_now   = (key_hash_now ^ {24'd0, b}) * pkhash_pkg::FNV_PRIME;
        key_at_start   = 1'b0;
        key_prev_slash = (b == pkhash_pkg::CHAR_SLASH);
    endtask

    task automatic track_key_byte(input logic [7:0] raw, input logic last);
        logic [7:0]                 ch;
        pkhash_pkg::pkhash_result_t res;
        ch = (raw == pkhash_pkg::CHAR_BACKSLASH) ? pkhash_pkg::CHAR_SLASH : raw;
        if (key_at_start)
        begin
            if (key_held_dot)
            begin
                key_held_dot = 1'b0;
                if (ch != pkhash_pkg::CHAR_SLASH)
                begin
                    fold_key_char(pkhash_pkg::CHAR_DOT);
                    fold_key_char(ch);
                end
            end
            else if (ch == pkhash_pkg::CHAR_DOT)
                key_held_dot = 1'b1;
            else if (ch != pkhash_pkg::CHAR_SLASH)
                fold_key_char(ch);
        end
        else if (!(ch == pkhash_pkg::CHAR_SLASH && key_prev_slash))
            fold_key_char(ch);
        if (last)
        begin
            if (key_held_dot)
            begin
                key_held_dot = 1'b0;
                fold_key_char(pkhash_pkg::CHAR_DOT);
            end
            res.hash  = key_hash_now;
            res.empty = key_at_start;
            key_result_q.insert(key_result_q.size(), res);
            clear_key_state();
        end
    endtask

    task automatic send_key_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        track_key_byte(b, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_key_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_key_buf();
        for (int i = 0; i < key_buf.size(); i++)
            send_key_byte(key_buf[i], i == key_buf.size() - 1);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (key_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_key_char();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return pkhash_pkg::CHAR_SLASH;
        else if (r < 22)
            return pkhash_pkg::CHAR_BACKSLASH;
        else if (r < 35)
            return pkhash_pkg::CHAR_DOT;
        else if (r < 55)
            return pkhash_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
        else if (r < 80)
            return pkhash_pkg::CHAR_UPPER_A + pkhash_pkg::CASE_OFFSET
                   + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        send_text(".");
        send_text("./");
        send_text("\\Z");
        send_text("..");
        send_text(".A");
        send_text("a//\\b");
        send_text("@[`{");
        send_key_byte(8'h00, 1'b0);
        send_key_byte(8'hFF, 1'b1);
        send_text("./.\\x/");
    endtask

    task automatic test_random_keys(input int tx_pct, input int rx_pct);
        int sent;
        int body_len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < BYTES_PER_PHASE)
        begin
            key_buf.delete();
            if ($urandom_range(99) < 35)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    add_key_char(pkhash_pkg::CHAR_DOT);
                    add_key_char(($urandom_range(1)) ? pkhash_pkg::CHAR_SLASH
                                                     : pkhash_pkg::CHAR_BACKSLASH);
                end
            end
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 3)) add_key_char(pkhash_pkg::CHAR_SLASH);
            if ($urandom_range(99) < 10)
                add_key_char(pkhash_pkg::CHAR_DOT);
            body_len = ($urandom_range(99) < 5) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 10);
            if (key_buf.size() == 0 && body_len == 0)
                body_len = 1;
            repeat (body_len) add_key_char(pick_key_char());
            send_key_buf();
            sent += key_buf.size();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (key_result_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: hash %h empty %b", m_tdata, m_tuser[0]);
            end
            else
            begin
                pkhash_pkg::pkhash_result_t exp_res;
                exp_res = key_result_q.pop_front();
                if (m_tdata !== exp_res.hash || m_tuser[0] !== exp_res.empty)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: hash exp %h got %h, empty exp %b got %b",
                                 exp_res.hash, m_tdata, exp_res.empty, m_tuser[0]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        clear_key_state();
        tx_idle_pct = 24;
        rx_idle_pct = 81;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_for_results();
        test_random_keys(24, 81);
        test_random_keys(81, 24);
        test_random_keys(0, 0);
        wait_for_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pkhash_pkg.sv
rtl/pkhash_step.sv
rtl/path_key_normalize_hash_top.sv
verif/path_key_normalize_hash_top_test.sv
